/* design/assert_macros.svh */
// assert_macros.svh: assertion helper macros shared by the interpolator modules
// each use expects signals named clock and reset in its scope
// no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PLI_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define PLI_ASSERT(label, prop, msg)
`define PLI_NEVER(label, expr, msg)
`endif
`endif

/* design/pli_pkg.sv */
// pli_pkg: types and codes shared by the interpolator controller, datapath and top level
// no dependencies
package pli_pkg;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_WAIT_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      STATUS_INTERP   = 2'd0,
      STATUS_CLAMP_LO = 2'd1,
      STATUS_CLAMP_HI = 2'd2,
      STATUS_NO_SEG   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RES_CUR_Y,
      RES_PREV_Y,
      RES_ZERO,
      RES_INTERP
   } res_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic        capture_x;
      logic        save_prev;
      logic        setup_math;
      logic        mul_step;
      logic        div_step;
      logic        res_load;
      res_sel_type res_sel;
      status_type  res_status;
      logic        out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic x_lt_cur;
      logic x_gt_cur;
      logic x_lt_prev;
      logic seg_zero_width;
      logic out_free;
   } dp_stat_type;

endpackage

/* design/pli_ram.sv */
// pli_ram: generic one-write one-read memory with registered read data
// no dependencies
module pli_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pli_ctrl.sv */
// pli_ctrl: sequencer for knot loads, clamp checks, segment scan, multiply and divide
// depends on pli_pkg and assert_macros.svh
`include "assert_macros.svh"
module pli_ctrl #(
   parameter int MAX_POINTS  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [$clog2(MAX_POINTS):0]   csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_kind,
   input  pli_pkg::dp_stat_type          stat,
   output pli_pkg::dp_cmd_type           cmd,
   output logic [$clog2(MAX_POINTS)-1:0] rd_addr
);
   import pli_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = AW + 1;
   localparam int W1 = VALUE_WIDTH + 1;
   localparam int SW = $clog2(W1);
   localparam logic [SW-1:0] STEP_LAST = SW'(W1 - 1);

   ctl_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [SW-1:0] step_ff, step_in;
   logic [CW-1:0] n_eff;
   logic [AW-1:0] last_idx;
   logic          n_one;
   logic          hit;

   // knot count in use: zero reads as one, and a count past the table size is clamped to it
   always_comb begin
      if (count_ff == '0) begin
         n_eff = CW'(1);
      end else if (count_ff > CW'(MAX_POINTS)) begin
         n_eff = CW'(MAX_POINTS);
      end else begin
         n_eff = count_ff;
      end
   end

   assign last_idx = AW'(n_eff - CW'(1));
   assign n_one    = (n_eff == CW'(1));
   assign hit      = !stat.x_lt_prev && !stat.x_gt_cur;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_kind == KIND_QUERY) begin
               state_in = ST_CHK_LO;
            end
         end
         ST_CHK_LO: begin
            state_in = stat.x_lt_cur ? ST_WAIT_OUT : ST_CHK_HI;
         end
         ST_CHK_HI: begin
            state_in = (stat.x_gt_cur || n_one) ? ST_WAIT_OUT : ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = stat.seg_zero_width ? ST_WAIT_OUT : ST_MUL;
            end else if (idx_ff == last_idx) begin
               state_in = ST_WAIT_OUT;
            end
         end
         ST_MUL: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_WAIT_OUT;
         end
         ST_WAIT_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.res_sel    = RES_ZERO;
      cmd.res_status = STATUS_INTERP;
      rd_addr        = '0;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == KIND_QUERY) begin
                  cmd.capture_x = 1'b1;
                  cmd.rd_en     = 1'b1;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_CHK_LO: begin
            cmd.save_prev = 1'b1;
            if (stat.x_lt_cur) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RES_CUR_Y;
               cmd.res_status = STATUS_CLAMP_LO;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = last_idx;
            end
         end
         ST_CHK_HI: begin
            if (stat.x_gt_cur) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RES_CUR_Y;
               cmd.res_status = STATUS_CLAMP_HI;
            end else if (n_one) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RES_PREV_Y;
               cmd.res_status = STATUS_INTERP;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = AW'(1);
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (stat.seg_zero_width) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_sel    = RES_CUR_Y;
                  cmd.res_status = STATUS_INTERP;
               end else begin
                  cmd.setup_math = 1'b1;
               end
            end else if (idx_ff == last_idx) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RES_ZERO;
               cmd.res_status = STATUS_NO_SEG;
            end else begin
               cmd.save_prev = 1'b1;
               cmd.rd_en     = 1'b1;
               rd_addr       = idx_ff + AW'(1);
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_SUM: begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RES_INTERP;
            cmd.res_status = STATUS_INTERP;
         end
         ST_WAIT_OUT: begin
            cmd.out_load = stat.out_free;
         end
      endcase
   end

   // counters and the count register
   always_comb begin
      count_in = csr_wr_en ? csr_wr_data : count_ff;
      idx_in   = idx_ff;
      step_in  = '0;
      if (state_ff == ST_CHK_HI) begin
         idx_in = AW'(1);
      end else if (state_ff == ST_SCAN && cmd.save_prev) begin
         idx_in = idx_ff + AW'(1);
      end
      if ((state_ff == ST_MUL || state_ff == ST_DIV) && step_ff != STEP_LAST) begin
         step_in = step_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= CW'(2);
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

   `PLI_ASSERT(a_scan_idx_range, (state_ff == ST_SCAN) |-> (idx_ff != '0 && idx_ff <= last_idx), "scan index outside the knots in use")
   `PLI_ASSERT(a_query_starts, (req_tvalid && req_tready && req_kind == KIND_QUERY) |=> (state_ff == ST_CHK_LO), "accepted query did not start the lookup")
   `PLI_ASSERT(a_result_waits, cmd.res_load |=> (state_ff == ST_WAIT_OUT), "result staged without moving to the output wait")

endmodule

/* design/pli_dpath.sv */
// pli_dpath: knot memory, compare flags, shift-add multiplier, restoring divider, result registers
// depends on pli_pkg, pli_ram and assert_macros.svh
`include "assert_macros.svh"
module pli_dpath #(
   parameter int MAX_POINTS  = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pli_pkg::dp_cmd_type           cmd,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
   output pli_pkg::dp_stat_type          stat,
   input  logic [$clog2(MAX_POINTS)-1:0] req_index,
   input  logic [VALUE_WIDTH-1:0]        req_x,
   input  logic [VALUE_WIDTH-1:0]        req_y,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [VALUE_WIDTH-1:0]        rsp_value,
   output pli_pkg::status_type           rsp_status
);
   import pli_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int VW = VALUE_WIDTH;
   localparam int W1 = VW + 1;
   localparam int W2 = VW + 2;
   localparam logic [AW:0] MAX_IDX = (AW + 1)'(MAX_POINTS);

   logic                 wr_ok;
   logic [2*VW-1:0]      knot_rd;
   logic signed [VW-1:0] cur_x, cur_y;

   logic signed [VW-1:0] x_ff, x_in;
   logic signed [VW-1:0] prev_x_ff, prev_x_in;
   logic signed [VW-1:0] prev_y_ff, prev_y_in;
   logic signed [VW-1:0] y2_ff, y2_in;
   logic                 neg_ff, neg_in;
   logic [W1-1:0]        mdy_ff, mdy_in;
   logic [W1-1:0]        mdx_ff, mdx_in;
   logic [W1-1:0]        den_ff, den_in;
   logic [2*W1-1:0]      acc_ff, acc_in;
   logic [VW-1:0]        res_val_ff, res_val_in;
   status_type           res_st_ff, res_st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_val_ff, rsp_val_in;
   status_type           rsp_st_ff, rsp_st_in;

   logic signed [W1-1:0] dy_w, mdx_w, den_w;
   logic [W1-1:0]        dy_mag;
   logic [2*W1-1:0]      acc_mul;
   logic [W1:0]          rem_sh, rem_diff;
   logic                 q_bit;
   logic [2*W1-1:0]      acc_div;
   logic signed [W2-1:0] q_ext, term, sum_val;
   logic [VW-1:0]        sat_val;
   logic [VW-1:0]        res_mux;

   // knot store: y in the upper half, x in the lower half
   assign wr_ok = cmd.wr_en && ({1'b0, req_index} < MAX_IDX);

   pli_ram #(
      .WIDTH (2 * VW),
      .DEPTH (MAX_POINTS)
   ) u_knot_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (req_index),
      .wr_data ({req_y, req_x}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (knot_rd)
   );

   assign cur_x = $signed(knot_rd[VW-1:0]);
   assign cur_y = $signed(knot_rd[2*VW-1:VW]);

   assign stat.x_lt_cur       = (x_ff < cur_x);
   assign stat.x_gt_cur       = (x_ff > cur_x);
   assign stat.x_lt_prev      = (x_ff < prev_x_ff);
   assign stat.seg_zero_width = (cur_x == prev_x_ff);
   assign stat.out_free       = !rsp_valid_ff || rsp_tready;

   // segment setup: |y2-y1|, x2-x (never negative here), x2-x1
   always_comb begin
      dy_w   = W1'(cur_y) - W1'(prev_y_ff);
      mdx_w  = W1'(cur_x) - W1'(x_ff);
      den_w  = W1'(cur_x) - W1'(prev_x_ff);
      dy_mag = dy_w[W1-1] ? W1'(-dy_w) : W1'(dy_w);
   end

   // one multiplier bit per step, msb first
   assign acc_mul = {acc_ff[2*W1-2:0], 1'b0} + (mdx_ff[W1-1] ? {{W1{1'b0}}, mdy_ff} : '0);

   // restoring divide: remainder in the upper half, quotient shifts into the lower half
   always_comb begin
      rem_sh   = {acc_ff[2*W1-1:W1], acc_ff[W1-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      q_bit    = !rem_diff[W1];
      acc_div  = {(q_bit ? rem_diff[W1-1:0] : rem_sh[W1-1:0]), acc_ff[W1-2:0], q_bit};
   end

   // y2 plus the signed quotient, saturated
   always_comb begin
      q_ext   = $signed({1'b0, acc_ff[W1-1:0]});
      term    = neg_ff ? q_ext : -q_ext;
      sum_val = W2'(y2_ff) + term;
      if (sum_val[W2-1:VW-1] == '0 || sum_val[W2-1:VW-1] == '1) begin
         sat_val = sum_val[VW-1:0];
      end else if (sum_val[W2-1]) begin
         sat_val = {1'b1, {(VW - 1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(VW - 1){1'b1}}};
      end
   end

   always_comb begin
      unique case (cmd.res_sel)
         RES_CUR_Y:  res_mux = cur_y;
         RES_PREV_Y: res_mux = prev_y_ff;
         RES_ZERO:   res_mux = '0;
         RES_INTERP: res_mux = sat_val;
      endcase
   end

   always_comb begin
      x_in       = cmd.capture_x ? $signed(req_x) : x_ff;
      prev_x_in  = cmd.save_prev ? cur_x : prev_x_ff;
      prev_y_in  = cmd.save_prev ? cur_y : prev_y_ff;
      y2_in      = y2_ff;
      neg_in     = neg_ff;
      mdy_in     = mdy_ff;
      mdx_in     = mdx_ff;
      den_in     = den_ff;
      acc_in     = acc_ff;
      res_val_in = cmd.res_load ? res_mux : res_val_ff;
      res_st_in  = cmd.res_load ? cmd.res_status : res_st_ff;
      if (cmd.setup_math) begin
         y2_in  = cur_y;
         neg_in = dy_w[W1-1];
         mdy_in = dy_mag;
         mdx_in = mdx_w;
         den_in = den_w;
         acc_in = '0;
      end else if (cmd.mul_step) begin
         mdx_in = {mdx_ff[W1-2:0], 1'b0};
         acc_in = acc_mul;
      end else if (cmd.div_step) begin
         acc_in = acc_div;
      end
      rsp_val_in   = cmd.out_load ? res_val_ff : rsp_val_ff;
      rsp_st_in    = cmd.out_load ? res_st_ff : rsp_st_ff;
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      y2_ff      <= y2_in;
      neg_ff     <= neg_in;
      mdy_ff     <= mdy_in;
      mdx_ff     <= mdx_in;
      den_ff     <= den_in;
      acc_ff     <= acc_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_val_ff;
   assign rsp_status = rsp_st_ff;

   `PLI_ASSERT(a_div_rem_below_den, cmd.div_step |-> (acc_ff[2*W1-1:W1] < den_ff), "divider remainder not below the segment width")
   `PLI_ASSERT(a_den_nonzero, cmd.setup_math |=> (den_ff != '0), "interpolation started on a zero-width segment")
   `PLI_NEVER(a_no_out_overwrite, cmd.out_load && rsp_valid_ff && !rsp_tready, "output word overwritten while stalled")

endmodule

/* design/piecewise_linear_interpolator_core.sv */
// piecewise_linear_interpolator_core: knot table with linear interpolation between knots
// a load word is taken at once; a query that clamps low ends after the low check, one that clamps
// high or hits a single knot ends after the high check, and one that interpolates runs on through
// the one-knot-per-cycle segment scan and the bit-serial multiply and divide
// one query at a time; a new word is taken as soon as the result sits in the output register
// synchronous active-high reset clears control state and sets point_count to 2; knots are undefined
module piecewise_linear_interpolator_core #(
   parameter int  MAX_POINTS  = 64,
   parameter int  VALUE_WIDTH = 32,
   localparam int AW    = $clog2(MAX_POINTS),
   localparam int CW    = AW + 1,
   localparam int REQ_W = ((AW + 2 * VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // configuration: point_count
   input  logic             csr_wr_en,
   input  logic [CW-1:0]    csr_wr_data,
   // request stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // point_index, x_value, y_value, zero pad
   input  logic             req_tuser,   // kind
   // response stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // result_value, zero pad
   output logic [1:0]       rsp_tuser    // status
);
   import pli_pkg::*;

   dp_cmd_type              cmd;
   dp_stat_type             stat;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           req_index;
   logic [VALUE_WIDTH-1:0]  req_x;
   logic [VALUE_WIDTH-1:0]  req_y;
   logic [VALUE_WIDTH-1:0]  rsp_value;
   status_type              rsp_status;

   // unpack the request word, lowest field first
   assign req_index = req_tdata[AW-1:0];
   assign req_x     = req_tdata[AW +: VALUE_WIDTH];
   assign req_y     = req_tdata[AW + VALUE_WIDTH +: VALUE_WIDTH];

   // controller: count register, clamp and scan sequencing, multiply/divide step counts
   pli_ctrl #(
      .MAX_POINTS  (MAX_POINTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .stat        (stat),
      .cmd         (cmd),
      .rd_addr     (rd_addr)
   );

   // datapath: knot memory, compares, arithmetic, output register
   pli_dpath #(
      .MAX_POINTS  (MAX_POINTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .stat       (stat),
      .req_index  (req_index),
      .req_x      (req_x),
      .req_y      (req_y),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   // pack the response word; pad bits are zero
   assign rsp_tdata = RSP_W'(rsp_value);
   assign rsp_tuser = rsp_status;

endmodule

/* test/testbench.sv */
// testbench.sv: self-checking bench for piecewise_linear_interpolator_core (knot table lookup)
// depends on pli_pkg for the word kind and status codes; needs nothing else but the rtl
`timescale 1ns / 1ps

module testbench;
   import pli_pkg::*;

   localparam int KNOTS         = 64;
   localparam int QUERY_CYCLES  = KNOTS + 2 * 32 + 6;   // slowest query through the core
   localparam int RANDOM_WORDS  = 1600;

   // tracks the knot table and the point count, and keeps the answers still owed by the core
   class interp_checker;
      typedef struct {
         logic [31:0] value;
         status_type  status;
      } reading_type;

      logic signed [31:0] knot_x [KNOTS];
      logic signed [31:0] knot_y [KNOTS];
      logic [6:0]         count_reg = 7'd2;
      reading_type        owed_readings [$];
      int                 mismatches = 0;

      function void set_count(logic [6:0] v);
         count_reg = v;
      endfunction

      function int pending();
         return owed_readings.size();
      endfunction

      function reading_type interpolate(logic signed [31:0] x);
         reading_type r;
         int          n, i;
         longint      x1, x2, y1, y2, dy, mdy, mdx, den, q, sum;
         bit [127:0]  prod, quo;
         n = count_reg;
         if (n < 1) n = 1;
         if (n > KNOTS) n = KNOTS;
         r.value  = '0;
         r.status = STATUS_NO_SEG;
         if (x < knot_x[0]) begin
            r.value  = knot_y[0];
            r.status = STATUS_CLAMP_LO;
         end else if (x > knot_x[n-1]) begin
            r.value  = knot_y[n-1];
            r.status = STATUS_CLAMP_HI;
         end else if (n == 1) begin
            r.value  = knot_y[0];
            r.status = STATUS_INTERP;
         end else begin
            for (i = 0; i + 1 < n; i++) begin
               x1 = knot_x[i];
               x2 = knot_x[i+1];
               y1 = knot_y[i];
               y2 = knot_y[i+1];
               if (x1 <= x && x <= x2) begin
                  if (x1 == x2) begin
                     r.value = y2[31:0];
                  end else begin
                     // y2 + dy*(x-x2)/(x2-x1) with magnitudes, division truncating
                     dy   = y2 - y1;
                     mdy  = (dy < 0) ? -dy : dy;
                     mdx  = x2 - x;
                     den  = x2 - x1;
                     prod = mdy;
                     prod = prod * mdx;
                     quo  = prod / den;
                     q    = quo[63:0];
                     sum  = (dy < 0) ? y2 + q : y2 - q;
                     if (sum > 64'sd2147483647) r.value = 32'h7FFF_FFFF;
                     else if (sum < -64'sd2147483648) r.value = 32'h8000_0000;
                     else r.value = sum[31:0];
                  end
                  r.status = STATUS_INTERP;
                  break;
               end
            end
         end
         return r;
      endfunction

      function void note_word(logic kind, logic [5:0] idx, logic [31:0] x, logic [31:0] y);
         if (kind == KIND_LOAD) begin
            knot_x[idx] = x;
            knot_y[idx] = y;
         end else begin
            owed_readings.push_back(interpolate(x));
         end
      endfunction

      function void check_word(logic [31:0] value, logic [1:0] status);
         reading_type want;
         if (owed_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with nothing owed: value %h status %0d",
                        $realtime, value, status);
            return;
         end
         want = owed_readings.pop_front();
         if (value !== want.value || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result mismatch: expected value %h status %0d, got value %h status %0d",
                        $realtime, want.value, want.status, value, status);
         end
      endfunction
   endclass

   typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARELY} ready_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic [71:0] req_tdata   = '0;     // point_index, x_value, y_value, zero pad
   logic        req_tuser   = 1'b0;   // kind
   logic        rsp_tready  = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;            // result_value
   logic [1:0]  rsp_tuser;            // status

   interp_checker interp_chk = new;

   // knot table as the stimulus side planned it, used to aim queries at segments
   logic signed [31:0] plan_x [KNOTS];
   logic signed [31:0] plan_y [KNOTS];
   int                 plan_n;
   int                 burst_left   = 0;
   int                 results_seen = 0;

   always #10 clock = ~clock;

   piecewise_linear_interpolator_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // both handshakes sampled at the edge; results checked before the new word is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            interp_chk.check_word(rsp_tdata, rsp_tuser);
            results_seen++;
         end
         if (req_tvalid && req_tready)
            interp_chk.note_word(req_tuser, req_tdata[5:0], req_tdata[37:6], req_tdata[69:38]);
      end
   end

   // receiver: switches between stall patterns, with an occasional long hold-off
   initial begin
      ready_mode_type mode;
      int             mode_left, hold_left;
      bit             held_once;
      mode      = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      held_once = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
               // one guaranteed long hold so the core backs up onto its input
               if (!held_once && results_seen >= 200) begin
                  held_once = 1;
                  hold_left = 600;
               end else if ($urandom_range(0, 40) == 0) begin
                  hold_left = $urandom_range(150, 500);
               end
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= ($urandom_range(0, 1) == 1);
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 4) != 0);
               default:      rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // offer one word and hold it until taken; bursts of random length, then a random gap
   task automatic send_word(input logic kind, input logic [5:0] idx,
                            input logic [31:0] x, input logic [31:0] y);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, y, x, idx};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_knot(input int idx, input logic [31:0] x, input logic [31:0] y);
      plan_x[idx] = x;
      plan_y[idx] = y;
      send_word(KIND_LOAD, idx[5:0], x, y);
   endtask

   // point_index and y_value are don't-care on a query, so they carry noise
   task automatic query_at(input logic [31:0] x);
      send_word(KIND_QUERY, 6'($urandom), x, $urandom);
   endtask

   // drain: valid low, then wait until every owed result is in and a load has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (interp_chk.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(input logic [6:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      interp_chk.set_count(v);
      // zero reads as one knot, anything past the table as the whole table
      plan_n = (v == 0) ? 1 : (v > KNOTS) ? KNOTS : v;
   endtask

   // fill knots 0..n-1: mostly sorted, sometimes with repeated x, rarely left unsorted
   task automatic make_table(input int n);
      longint vals [$];
      longint center, v, r;
      int     style, ystyle, i;
      style  = $urandom_range(0, 2);
      ystyle = $urandom_range(0, 1);
      center = int'($urandom);
      for (i = 0; i < n; i++) begin
         case (style)
            0: v = int'($urandom);
            1: begin
               r = $urandom_range(0, 65536);
               v = center + r - 32768;
            end
            default: begin
               r = $urandom_range(0, 400000);
               v = r - 200000;
            end
         endcase
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         vals.push_back(v);
      end
      if ($urandom_range(0, 7) != 0) vals.sort();
      for (i = 1; i < n; i++)
         if ($urandom_range(0, 11) == 0) vals[i] = vals[i-1];
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 131072);
         load_knot(i, 32'(vals[i]), ystyle ? $urandom : 32'(r - 65536));
      end
   endtask

   // aim a query: inside a segment, on or next to a knot, off either end, at a full-scale extreme, or anywhere
   function automatic logic [31:0] pick_query_x();
      int     sel, i;
      longint lo, hi, off;
      sel = $urandom_range(0, 19);
      if (sel < 9 && plan_n > 1) begin
         i  = $urandom_range(0, plan_n - 2);
         lo = plan_x[i];
         hi = plan_x[i+1];
         if (lo > hi) begin
            off = lo;
            lo  = hi;
            hi  = off;
         end
         off = $urandom_range(0, 32'(hi - lo));
         return 32'(lo + off);
      end else if (sel < 13) begin
         i = $urandom_range(0, plan_n - 1);
         return plan_x[i] + ((sel == 11) ? -1 : (sel == 12) ? 1 : 0);
      end else if (sel < 15) begin
         return plan_x[0] - 1 - $urandom_range(0, 1000);
      end else if (sel < 17) begin
         return plan_x[plan_n-1] + 1 + $urandom_range(0, 1000);
      end else if (sel == 17) begin
         return 32'h8000_0000;
      end else if (sel == 18) begin
         return 32'h7FFF_FFFF;
      end
      return $urandom;
   endfunction

   initial begin
      int         random_words, len, k, i;
      logic [6:0] count_val;
      plan_n = 2;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table once so every later query reads written knots
      make_table(KNOTS);
      // point count still at its reset value of two
      query_at(pick_query_x());

      // extreme values: full-scale knots, a drop from max to min across nearly half the x range
      write_count(7'd4);
      load_knot(0, 32'h8000_0000, 32'h7FFF_FFFF);
      load_knot(1, -32'sd5, 32'h8000_0000);
      load_knot(2, -32'sd5, 32'd123);
      load_knot(3, 32'h7FFF_FFFF, 32'h8000_0000);
      query_at(32'h8000_0000);
      query_at(-32'sd5);
      query_at(-32'sd4);
      query_at(32'd0);
      query_at(32'h4000_0000);
      query_at(32'h7FFF_FFFF);

      // zero-width first segment, both clamps, plain interpolation
      write_count(7'd3);
      load_knot(0, 32'd10, 32'd7);
      load_knot(1, 32'd10, 32'd9);
      load_knot(2, 32'd20, -32'sd3);
      query_at(32'd10);
      query_at(32'd9);
      query_at(32'd21);
      query_at(32'd15);

      // single knot: on it, below, above
      write_count(7'd1);
      query_at(32'd10);
      query_at(32'd9);
      query_at(32'd11);

      // count of zero acts as one knot, count past the table as the full table
      write_count(7'd0);
      query_at(32'd10);
      write_count(7'd127);
      query_at(pick_query_x());
      query_at(pick_query_x());

      // random phases: new count, fresh table, then mostly queries with some reloads
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 11))
            0:       count_val = 7'd1;
            1:       count_val = 7'd64;
            2:       count_val = 7'd0;
            3:       count_val = 7'($urandom_range(65, 127));
            4:       count_val = 7'd2;
            default: count_val = 7'($urandom_range(3, 12));
         endcase
         write_count(count_val);
         make_table(plan_n);
         random_words += plan_n;
         len = $urandom_range(30, 120);
         for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
               // noise load anywhere; may leave the table unsorted
               0: load_knot($urandom_range(0, KNOTS - 1), $urandom, $urandom);
               // new ordinate on an existing knot; the x order of the table is left as it was
               1: begin
                  i = $urandom_range(0, plan_n - 1);
                  load_knot(i, plan_x[i], $urandom);
               end
               default: query_at(pick_query_x());
            endcase
         end
         random_words += len;
      end

      wait_idle();
      repeat (QUERY_CYCLES) @(posedge clock);
      if (interp_chk.mismatches == 0 && interp_chk.pending() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // hang guard, several times the slowest correct run
   initial begin
      #200_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
